// File: hw/rtl/khht_pkg.sv
// Package for the keyed handle hash table: request, response and slot types,
// operation and status codes, sequencer states and parameter defaults.
// No dependencies.
package khht_pkg;

	localparam int BUCKETS_DEF = 1024;
	localparam int WAYS_DEF    = 4;
	localparam int MASK_W      = 10;
	localparam logic [MASK_W-1:0] MASK_RESET = 10'h3FF;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_DUP       = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] device_id;
		logic [31:0] inode_number;
		logic [15:0] entry_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [15:0] result_handle;
	} rsp_t;

	typedef struct packed {
		logic [31:0] device;
		logic [31:0] inode;
		logic [15:0] handle;
	} slot_t;

	// summary of a bucket scan
	typedef struct packed {
		logic        hit;
		logic        free_ok;
		logic [15:0] handle;
	} scan_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

// File: hw/rtl/khht_store.sv
// Slot storage: per-bucket valid rows and per-slot key/handle data.
// Both memories have registered reads. Depends on khht_pkg.
module khht_store #(
	parameter int BUCKETS = khht_pkg::BUCKETS_DEF,
	parameter int WAYS    = khht_pkg::WAYS_DEF,
	localparam int BW     = $clog2(BUCKETS),
	localparam int SAW    = $clog2(BUCKETS * WAYS)
) (
	input  logic                clk,
	input  logic                vld_we,
	input  logic [BW-1:0]       vld_waddr,
	input  logic [WAYS-1:0]     vld_wdata,
	input  logic                vld_re,
	input  logic [BW-1:0]       vld_raddr,
	output logic [WAYS-1:0]     vld_rdata,
	input  logic                dat_we,
	input  logic [SAW-1:0]      dat_waddr,
	input  khht_pkg::slot_t     dat_wdata,
	input  logic [SAW-1:0]      dat_raddr,
	output khht_pkg::slot_t     dat_rdata
);
	import khht_pkg::*;

	logic [WAYS-1:0] vld_mem [BUCKETS];
	slot_t           dat_mem [BUCKETS*WAYS];
	logic [WAYS-1:0] vld_rd_q;
	slot_t           dat_rd_q;

	always_ff @(posedge clk) begin
		if (vld_we)
			vld_mem[vld_waddr] <= vld_wdata;
		if (vld_re)
			vld_rd_q <= vld_mem[vld_raddr];
	end

	always_ff @(posedge clk) begin
		if (dat_we)
			dat_mem[dat_waddr] <= dat_wdata;
		dat_rd_q <= dat_mem[dat_raddr];
	end

	assign vld_rdata = vld_rd_q;
	assign dat_rdata = dat_rd_q;

endmodule

// File: hw/rtl/khht_scan.sv
// Shared key comparator, stepped over the ways of one bucket, one way a cycle.
// Tracks the first matching way and the first free way. Depends on khht_pkg.
module khht_scan #(
	parameter int WAYS = khht_pkg::WAYS_DEF,
	localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             step,
	input  logic [WW-1:0]    way,
	input  logic             slot_vld,
	input  khht_pkg::slot_t  slot,
	input  logic [31:0]      device_id,
	input  logic [31:0]      inode_number,
	output khht_pkg::scan_t  scan,
	output logic [WW-1:0]    hit_way,
	output logic [WW-1:0]    free_way
);
	import khht_pkg::*;

	scan_t           scan_q;
	logic [WW-1:0]   hit_way_q;
	logic [WW-1:0]   free_way_q;
	logic            key_eq;

	assign key_eq = (slot.device == device_id) && (slot.inode == inode_number);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			hit_way_q  <= '0;
			free_way_q <= '0;
		end else if (start) begin
			scan_q     <= '0;
			hit_way_q  <= '0;
			free_way_q <= '0;
		end else if (step) begin
			if (slot_vld && key_eq && !scan_q.hit) begin
				scan_q.hit    <= 1'b1;
				scan_q.handle <= slot.handle;
				hit_way_q     <= way;
			end
			if (!slot_vld && !scan_q.free_ok) begin
				scan_q.free_ok <= 1'b1;
				free_way_q     <= way;
			end
		end
	end

	assign scan     = scan_q;
	assign hit_way  = hit_way_q;
	assign free_way = free_way_q;

endmodule

// File: hw/rtl/keyed_handle_hash_table.sv
// Keyed handle hash table: (device, inode) -> 16-bit handle, set associative.
// Top level with the request sequencer. Depends on khht_pkg, khht_store, khht_scan.
//
// Usage:
//   in_valid/in_ready carry one request (lookup, insert, remove) as req_t.
//   out_valid/out_ready carry one response per request as rsp_t.
//   cfg_we/cfg_wdata write index_mask; write it only while the table is idle.
// Timing:
//   A request is accepted in the idle state; the bucket's valid row and way 0
//   are read, then the shared comparator checks one way per cycle, then the
//   finish state writes back and loads the response register. A new request
//   is taken only after the sequencer has gone from the finish state back to
//   idle, so requests are not overlapped.
// Reset:
//   index_mask returns to 1023 and a clearing pass zeroes the valid rows,
//   one bucket per cycle (all BUCKETS rows, 1024 by default); in_ready is low
//   meanwhile.
// Stall:
//   the response register holds while out_ready is low; a request already
//   accepted waits in its final step until the register is free.
module keyed_handle_hash_table #(
	parameter int BUCKETS = khht_pkg::BUCKETS_DEF,
	parameter int WAYS    = khht_pkg::WAYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  khht_pkg::req_t                in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output khht_pkg::rsp_t                out_data,
	input  logic                          cfg_we,
	input  logic [khht_pkg::MASK_W-1:0]   cfg_wdata
);
	import khht_pkg::*;

	localparam int BW  = $clog2(BUCKETS);
	localparam int SAW = $clog2(BUCKETS * WAYS);
	localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;

	state_t            state_q, state_d;
	logic [MASK_W-1:0] mask_q;
	req_t              req_q;
	logic [BW-1:0]     bucket_q;
	logic [WW-1:0]     way_q;
	logic [BW-1:0]     clr_q;
	logic              out_valid_q;
	rsp_t              out_data_q;

	logic [BW-1:0]     mask_bw;
	logic [BW-1:0]     bucket_in;
	logic              accept;
	logic              last_way;
	logic [WW-1:0]     next_way;
	logic              out_free;
	logic              clr_done;

	// sequencer outputs
	logic              clr_we;
	logic              scan_step;
	logic              fin_go;

	logic              vld_we;
	logic [BW-1:0]     vld_waddr;
	logic [WAYS-1:0]   vld_wdata;
	logic [WAYS-1:0]   vld_row;
	logic              dat_we;
	logic [SAW-1:0]    dat_waddr;
	logic [SAW-1:0]    dat_raddr;
	slot_t             dat_wdata;
	slot_t             dat_rdata;

	scan_t             scan;
	logic [WW-1:0]     hit_way;
	logic [WW-1:0]     free_way;

	logic              ins_ok;
	logic              rem_hit;
	logic [WAYS-1:0]   row_new;
	rsp_t              rsp;

	// mask bits above the table size are dropped
	always_comb begin
		for (int i = 0; i < BW; i++)
			mask_bw[i] = (i < MASK_W) ? mask_q[i % MASK_W] : 1'b0;
	end

	assign bucket_in = in_data.inode_number[BW-1:0] & mask_bw;
	assign accept    = in_valid && in_ready;
	assign last_way  = (way_q == WW'(WAYS - 1));
	assign next_way  = last_way ? way_q : way_q + 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign clr_done  = (clr_q == BW'(BUCKETS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_done) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_SCAN;
			ST_SCAN:   if (last_way) state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		clr_we    = 1'b0;
		scan_step = 1'b0;
		fin_go    = 1'b0;
		unique case (state_q)
			ST_CLEAR:  clr_we    = 1'b1;
			ST_IDLE:   in_ready  = 1'b1;
			ST_SCAN:   scan_step = 1'b1;
			ST_FINISH: fin_go    = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			mask_q      <= MASK_RESET;
			clr_q       <= '0;
			way_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				mask_q <= cfg_wdata;
			if (clr_we)
				clr_q <= clr_q + 1'b1;
			if (accept)
				way_q <= '0;
			else if (scan_step)
				way_q <= next_way;
			if (fin_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= in_data;
			bucket_q <= bucket_in;
		end
		if (fin_go)
			out_data_q <= rsp;
	end

	// read address runs one way ahead of the comparator
	always_comb begin
		if (state_q == ST_IDLE)
			dat_raddr = SAW'(bucket_in) * SAW'(WAYS);
		else
			dat_raddr = SAW'(bucket_q) * SAW'(WAYS) + SAW'(next_way);
	end

	khht_store #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_store (
		.clk       (clk),
		.vld_we    (vld_we),
		.vld_waddr (vld_waddr),
		.vld_wdata (vld_wdata),
		.vld_re    (accept),
		.vld_raddr (bucket_in),
		.vld_rdata (vld_row),
		.dat_we    (dat_we),
		.dat_waddr (dat_waddr),
		.dat_wdata (dat_wdata),
		.dat_raddr (dat_raddr),
		.dat_rdata (dat_rdata)
	);

	khht_scan #(
		.WAYS (WAYS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept),
		.step         (scan_step),
		.way          (way_q),
		.slot_vld     (vld_row[way_q]),
		.slot         (dat_rdata),
		.device_id    (req_q.device_id),
		.inode_number (req_q.inode_number),
		.scan         (scan),
		.hit_way      (hit_way),
		.free_way     (free_way)
	);

	// response and write-back
	always_comb begin
		ins_ok            = 1'b0;
		rem_hit           = 1'b0;
		rsp.found         = scan.hit;
		rsp.result_handle = scan.hit ? scan.handle : 16'd0;
		priority if (req_q.req_type == REQ_INSERT) begin
			if (scan.hit)
				rsp.status = STAT_DUP;
			else if (!scan.free_ok)
				rsp.status = STAT_FULL;
			else begin
				rsp.status = STAT_OK;
				ins_ok     = 1'b1;
			end
		end else if (req_q.req_type == REQ_REMOVE) begin
			rsp.status = scan.hit ? STAT_OK : STAT_NOT_FOUND;
			rem_hit    = scan.hit;
		end else begin
			// lookup and the reserved code
			rsp.status = scan.hit ? STAT_OK : STAT_NOT_FOUND;
		end
	end

	always_comb begin
		row_new = vld_row;
		if (ins_ok)
			row_new[free_way] = 1'b1;
		if (rem_hit)
			row_new[hit_way] = 1'b0;
	end

	assign vld_we    = clr_we || (fin_go && (ins_ok || rem_hit));
	assign vld_waddr = clr_we ? clr_q : bucket_q;
	assign vld_wdata = clr_we ? '0 : row_new;

	assign dat_we           = fin_go && ins_ok;
	assign dat_waddr        = SAW'(bucket_q) * SAW'(WAYS) + SAW'(free_way);
	assign dat_wdata.device = req_q.device_id;
	assign dat_wdata.inode  = req_q.inode_number;
	assign dat_wdata.handle = req_q.entry_handle;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SCAN)
		else $error("accepted request did not start a scan");

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_FULL |-> !out_data.found)
		else $error("full bucket reported with a present key");

	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_DUP |-> out_data.found)
		else $error("duplicate reported without a present key");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({clr_we, scan_step, fin_go, in_ready}))
		else $error("sequencer phases overlap");

endmodule
